>>> src/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg: shared types and constants for the SHA-256 message digest
// Command and status structs between controller and datapath, round
// constants, initial hash values and padding constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smd_pkg;

	localparam int unsigned WORD_BITS    = 32;
	localparam int unsigned BLOCK_WORDS  = 16;
	localparam int unsigned HASH_WORDS   = 8;
	localparam int unsigned ROUNDS       = 64;
	localparam int unsigned WORD_BYTES   = 4;

	localparam logic [6:0]  BLOCK_BYTES  = 7'd64;
	localparam logic [6:0]  PAD_LIMIT    = 7'd56;
	localparam logic [31:0] PAD_WORD     = 32'h8000_0000;
	localparam logic [3:0]  LEN_HI_IDX   = 4'd14;
	localparam logic [3:0]  LEN_LO_IDX   = 4'd15;
	localparam logic [2:0]  MAX_BYTES    = 3'd4;
	localparam logic [5:0]  LAST_ROUND   = 6'(ROUNDS - 1);
	localparam logic [2:0]  LAST_INDEX   = 3'd7;

	// source of the bytes that an insert step packs into the block
	typedef enum logic [1:0] {
		SRC_IN,
		SRC_PEND,
		SRC_PAD
	} src_t;

	typedef struct packed {
		logic insert;
		src_t src;
		logic init;
		logic round;
		logic finish;
		logic write_len;
		logic out_next;
		logic msg_reset;
	} cmd_t;

	typedef struct packed {
		logic will_full;
		logic rem_zero;
		logic fill_gt56;
		logic round_last;
		logic out_last;
	} status_t;

	function automatic logic [31:0] iv_word(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/smd_datapath.sv
// ----------------------------------------------------------------------------
// smd_datapath: block buffer, schedule, round logic and hash state
// Packs message bytes into the 512-bit block, runs one compression round
// per cycle on a shifting 16-word schedule window and holds the digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smd_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [31:0]    msg_word,
	input  wire logic [2:0]     byte_count,
	input  wire smd_pkg::cmd_t  cmd,
	output smd_pkg::status_t    sts,
	output logic [31:0]         digest_word,
	output logic [2:0]          word_index,
	output logic                last_word
);

	logic [31:0] hash_q [smd_pkg::HASH_WORDS];
	logic [31:0] hash_d [smd_pkg::HASH_WORDS];
	logic [31:0] v_q    [smd_pkg::HASH_WORDS];
	logic [31:0] v_d    [smd_pkg::HASH_WORDS];
	logic [31:0] win_q  [smd_pkg::BLOCK_WORDS];
	logic [31:0] win_d  [smd_pkg::BLOCK_WORDS];

	logic [6:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic [31:0] pend_word_q;
	logic [2:0]  pend_rem_q;

	logic [31:0] sw;
	logic [2:0]  sn;
	logic [5:0]  pos;
	logic [5:0]  p;
	logic [6:0]  room;
	logic [6:0]  sum;
	logic        full;
	logic [2:0]  k;
	logic [2:0]  rem_next;
	logic [31:0] word_next;

	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (smd_pkg::WORD_BITS - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// byte source for the insert step
	always_comb begin
		case (cmd.src)
			smd_pkg::SRC_IN: begin
				sw = msg_word;
				sn = (byte_count > smd_pkg::MAX_BYTES) ? smd_pkg::MAX_BYTES : byte_count;
			end
			smd_pkg::SRC_PAD: begin
				sw = smd_pkg::PAD_WORD;
				sn = 3'd1;
			end
			default: begin
				sw = pend_word_q;
				sn = pend_rem_q;
			end
		endcase
	end

	assign pos       = fill_q[5:0];
	assign room      = smd_pkg::BLOCK_BYTES - fill_q;
	assign sum       = {1'b0, pos} + {4'b0000, sn};
	assign full      = sum[6];
	assign k         = full ? room[2:0] : sn;
	assign rem_next  = sn - k;
	assign word_next = sw << {k, 3'b000};

	assign w_new = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ smd_pkg::round_k(rnd_q) + win_q[0];
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		p = '0;
		for (int j = 0; j < smd_pkg::BLOCK_WORDS; j++) begin
			win_d[j] = win_q[j];
		end
		if (cmd.round) begin
			for (int j = 0; j < smd_pkg::BLOCK_WORDS - 1; j++) begin
				win_d[j] = win_q[j + 1];
			end
			win_d[smd_pkg::BLOCK_WORDS - 1] = w_new;
		end else if (cmd.finish) begin
			for (int j = 0; j < smd_pkg::BLOCK_WORDS; j++) begin
				win_d[j] = '0;
			end
		end else if (cmd.write_len) begin
			win_d[smd_pkg::LEN_HI_IDX] = len_q[63:32];
			win_d[smd_pkg::LEN_LO_IDX] = len_q[31:0];
		end else if (cmd.insert) begin
			// padding: everything after the marker byte reads as zero
			if (cmd.src == smd_pkg::SRC_PAD) begin
				for (int j = 0; j < smd_pkg::BLOCK_WORDS; j++) begin
					for (int l = 0; l < smd_pkg::WORD_BYTES; l++) begin
						if (6'(j * 4 + l) > pos) begin
							win_d[j][8 * (3 - l) +: 8] = 8'h00;
						end
					end
				end
			end
			for (int i = 0; i < smd_pkg::WORD_BYTES; i++) begin
				if (3'(i) < k) begin
					p = pos + 6'(i);
					win_d[p[5:2]][{~p[1:0], 3'b000} +: 8] = sw[8 * (3 - i) +: 8];
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < smd_pkg::HASH_WORDS; j++) begin
			v_d[j]    = v_q[j];
			hash_d[j] = hash_q[j];
		end
		if (cmd.init) begin
			for (int j = 0; j < smd_pkg::HASH_WORDS; j++) begin
				v_d[j] = hash_q[j];
			end
		end else if (cmd.round) begin
			v_d[7] = v_q[6];
			v_d[6] = v_q[5];
			v_d[5] = v_q[4];
			v_d[4] = v_q[3] + t1;
			v_d[3] = v_q[2];
			v_d[2] = v_q[1];
			v_d[1] = v_q[0];
			v_d[0] = t1 + t2;
		end
		if (cmd.msg_reset) begin
			for (int j = 0; j < smd_pkg::HASH_WORDS; j++) begin
				hash_d[j] = smd_pkg::iv_word(3'(j));
			end
		end else if (cmd.finish) begin
			for (int j = 0; j < smd_pkg::HASH_WORDS; j++) begin
				hash_d[j] = hash_q[j] + v_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < smd_pkg::HASH_WORDS; j++) begin
				hash_q[j] <= smd_pkg::iv_word(3'(j));
			end
			fill_q     <= '0;
			len_q      <= '0;
			rnd_q      <= '0;
			idx_q      <= '0;
			pend_rem_q <= '0;
		end else begin
			for (int j = 0; j < smd_pkg::HASH_WORDS; j++) begin
				hash_q[j] <= hash_d[j];
			end
			if (cmd.msg_reset || cmd.finish) begin
				fill_q <= '0;
			end else if (cmd.insert) begin
				fill_q <= fill_q + {4'b0000, k};
			end
			if (cmd.msg_reset) begin
				len_q <= '0;
			end else if (cmd.insert && cmd.src == smd_pkg::SRC_IN) begin
				len_q <= len_q + {58'd0, sn, 3'b000};
			end
			if (cmd.round) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.out_next) begin
				idx_q <= idx_q + 3'd1;
			end
			if (cmd.insert) begin
				pend_rem_q <= rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < smd_pkg::HASH_WORDS; j++) begin
			v_q[j] <= v_d[j];
		end
		for (int j = 0; j < smd_pkg::BLOCK_WORDS; j++) begin
			win_q[j] <= win_d[j];
		end
		if (cmd.insert) begin
			pend_word_q <= word_next;
		end
	end

	assign sts.will_full  = full;
	assign sts.rem_zero   = (pend_rem_q == 3'd0);
	assign sts.fill_gt56  = (fill_q > smd_pkg::PAD_LIMIT);
	assign sts.round_last = (rnd_q == smd_pkg::LAST_ROUND);
	assign sts.out_last   = (idx_q == smd_pkg::LAST_INDEX);

	assign digest_word = hash_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == smd_pkg::LAST_INDEX);

endmodule

`default_nettype wire

>>> src/smd_ctrl.sv
// ----------------------------------------------------------------------------
// smd_ctrl: sequencer for the SHA-256 message digest
// Accepts words, starts compressions, walks the padding steps and hands
// out the eight digest words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              msg_valid,
	output logic                   msg_stall,
	input  wire logic              end_of_message,
	output logic                   digest_valid,
	input  wire logic              digest_stall,
	input  wire smd_pkg::status_t  sts,
	output smd_pkg::cmd_t          cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_FINISH,
		S_REM,
		S_PAD,
		S_PAD_CHK,
		S_LEN,
		S_OUT
	} state_t;

	// which step of the message the running compression belongs to
	typedef enum logic [1:0] {
		PH_DATA,
		PH_PAD,
		PH_FINAL
	} phase_t;

	state_t state_q;
	phase_t ph_q;
	logic   eom_q;

	assign msg_stall    = (state_q != S_IDLE);
	assign digest_valid = (state_q == S_OUT);

	always_comb begin
		cmd     = '0;
		cmd.src = smd_pkg::SRC_PEND;
		case (state_q)
			S_IDLE: begin
				cmd.src    = smd_pkg::SRC_IN;
				cmd.insert = msg_valid;
				cmd.init   = msg_valid && sts.will_full;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
			end
			S_REM: begin
				cmd.insert = 1'b1;
			end
			S_PAD: begin
				cmd.src    = smd_pkg::SRC_PAD;
				cmd.insert = 1'b1;
				cmd.init   = sts.will_full;
			end
			S_PAD_CHK: begin
				cmd.init = sts.fill_gt56;
			end
			S_LEN: begin
				cmd.write_len = 1'b1;
				cmd.init      = 1'b1;
			end
			S_OUT: begin
				cmd.out_next  = !digest_stall;
				cmd.msg_reset = !digest_stall && sts.out_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_DATA;
			eom_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (msg_valid) begin
						eom_q <= end_of_message;
						if (sts.will_full) begin
							ph_q    <= PH_DATA;
							state_q <= S_ROUND;
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_ROUND: begin
					if (sts.round_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					case (ph_q)
						PH_DATA: begin
							if (!sts.rem_zero) begin
								state_q <= S_REM;
							end else if (eom_q) begin
								state_q <= S_PAD;
							end else begin
								state_q <= S_IDLE;
							end
						end
						PH_PAD: begin
							state_q <= S_LEN;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_REM: begin
					state_q <= eom_q ? S_PAD : S_IDLE;
				end
				S_PAD: begin
					if (sts.will_full) begin
						ph_q    <= PH_PAD;
						state_q <= S_ROUND;
					end else begin
						state_q <= S_PAD_CHK;
					end
				end
				S_PAD_CHK: begin
					// no room for the length: zero-fill this block and compress
					if (sts.fill_gt56) begin
						ph_q    <= PH_PAD;
						state_q <= S_ROUND;
					end else begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					ph_q    <= PH_FINAL;
					state_q <= S_ROUND;
				end
				S_OUT: begin
					if (!digest_stall && sts.out_last) begin
						eom_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/sha256_message_digest_top.sv
// ----------------------------------------------------------------------------
// sha256_message_digest_top: streaming SHA-256 message digest
// Byte-granular message input, standard padding, eight-word digest output.
// ----------------------------------------------------------------------------
// A message word is taken whenever the block is idle and is packed
// straight into the 64-byte block buffer. Each full block then runs 64
// rounds, one per cycle through the single round datapath, and a finish
// step that folds the working variables into the hash. The remaining
// bytes of a word that crosses a block boundary are packed in an extra
// step after that compression. At the end of the message the padding
// steps (marker byte, length check, length words) are followed by one or
// two more block compressions, then the eight digest words go out one per
// cycle that is not stalled; the block takes no new message word until the
// last digest word has been taken, and then starts the next message from the
// initial hash values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_digest_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        msg_valid,
	output logic             msg_stall,
	input  wire logic [31:0] msg_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        end_of_message,
	output logic             digest_valid,
	input  wire logic        digest_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	smd_pkg::cmd_t    cmd;
	smd_pkg::status_t sts;

	smd_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_stall      (msg_stall),
		.end_of_message (end_of_message),
		.digest_valid   (digest_valid),
		.digest_stall   (digest_stall),
		.sts            (sts),
		.cmd            (cmd)
	);

	smd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_word    (msg_word),
		.byte_count  (byte_count),
		.cmd         (cmd),
		.sts         (sts),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

`default_nettype wire
